FILE: hdl/wsq_pkg.sv
package wsq_pkg;

   localparam int QUEUE_DEPTH_DEF = 256;
   localparam int NUM_QUEUES_DEF  = 16;
   localparam int MAX_STEAL_DEF   = 16;

   localparam int ITEM_W  = 64;
   localparam int SEL_W   = 4;
   localparam int SEL_COUNT = 16;
   localparam int DEPTH_W = 9;
   localparam int LIMIT_W = 5;

   localparam logic [LIMIT_W-1:0] STEAL_LIMIT_RESET = 5'd4;

   // Entries of the command queue between the front and the back.
   localparam int CMD_FIFO_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_STEAL = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_DATA
   } back_state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SEL_W-1:0]  queue_sel;
      logic [ITEM_W-1:0] push_item;
   } req_type;

   typedef struct packed {
      logic [ITEM_W-1:0]  out_item;
      status_type         status;
      logic               last;
      logic [DEPTH_W-1:0] depth_left;
      logic               work_hint;
   } rsp_type;

   // A classified command: the queue index is already wrapped into range.
   typedef struct packed {
      kind_type          kind;
      logic [SEL_W-1:0]  q;
      logic [ITEM_W-1:0] item;
   } cmd_type;

endpackage

FILE: hdl/wsq_ram.sv
module wsq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/wsq_front.sv
module wsq_front import wsq_pkg::*; #(
   parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_pop
);

   localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   logic [SEL_W-1:0] qmap [SEL_COUNT];

   // Queue selectors beyond the bank wrap around; the map is fixed at elaboration.
   for (genvar i = 0; i < SEL_COUNT; i++) begin : g_qmap
      localparam int QI = i % NUM_QUEUES;
      assign qmap[i] = SEL_W'(QI);
   end

   cmd_type          ent_ff [CMD_FIFO_DEPTH];
   cmd_type          ent_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   always_comb begin
      ent_in.kind = kind_type'(req_data.kind);
      ent_in.q    = qmap[req_data.queue_sel];
      ent_in.item = req_data.push_item;
   end

   assign req_ready = (count_ff != CNT_W'(CMD_FIFO_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = ent_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= ent_in;
      end
   end

endmodule

FILE: hdl/wsq_back.sv
module wsq_back import wsq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
   parameter int MAX_STEAL   = MAX_STEAL_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] steal_limit,
   input  logic               cmd_valid,
   input  cmd_type            cmd_data,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   localparam int IW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CW = $clog2(MAX_STEAL + 1);
   localparam int RAM_DEPTH = 2 ** (QW + AW);

   back_state_type     state_ff, state_in;
   logic [IW-1:0]      head_ff [NUM_QUEUES];
   logic [IW-1:0]      tail_ff [NUM_QUEUES];
   logic               hint_ff [NUM_QUEUES];
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [CW-1:0]      remain_ff, remain_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [QW-1:0]      rd_q_ff, rd_q_in;
   logic [DEPTH_W-1:0] run_depth_ff, run_depth_in;
   logic               run_hint_ff, run_hint_in;

   logic [QW-1:0]      qi;
   logic [IW-1:0]      h, t, tm1, avail;
   logic               hint;
   logic               empty, full, slot_free;
   logic [CW-1:0]      lim_eff, take;
   logic               upd_en;
   logic [IW-1:0]      new_h, new_t;
   logic               new_hint;
   logic [DEPTH_W-1:0] new_depth;
   status_type         imm_status;
   logic               imm_rsp;

   logic               ram_we, ram_re;
   logic [QW+AW-1:0]   ram_waddr, ram_raddr;
   logic [ITEM_W-1:0]  ram_rdata;

   assign qi        = QW'(cmd_data.q);
   assign h         = head_ff[qi];
   assign t         = tail_ff[qi];
   assign hint      = hint_ff[qi];
   assign tm1       = t - 1'b1;
   assign avail     = t - h;
   assign empty     = (h >= t);
   assign full      = (t >= IW'(QUEUE_DEPTH));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (steal_limit == '0) begin
         lim_eff = CW'(1);
      end else if (32'(steal_limit) > MAX_STEAL) begin
         lim_eff = CW'(MAX_STEAL);
      end else begin
         lim_eff = CW'(steal_limit);
      end
      take = (32'(avail) < 32'(lim_eff)) ? CW'(avail) : lim_eff;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_pop      = 1'b0;
      upd_en       = 1'b0;
      new_h        = h;
      new_t        = t;
      new_hint     = hint;
      imm_rsp      = 1'b0;
      imm_status   = STATUS_OK;
      ram_we       = 1'b0;
      ram_waddr    = {qi, t[AW-1:0]};
      ram_re       = 1'b0;
      ram_raddr    = {rd_q_ff, rd_idx_ff};
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      remain_in    = remain_ff;
      rd_idx_in    = rd_idx_ff;
      rd_q_in      = rd_q_ff;
      run_depth_in = run_depth_ff;
      run_hint_in  = run_hint_ff;
      new_depth    = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               upd_en  = 1'b1;
               imm_rsp = 1'b1;
               unique case (cmd_data.kind)
                  KIND_PUSH: begin
                     if (full) begin
                        imm_status = STATUS_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        new_t    = t + 1'b1;
                        new_hint = 1'b1;
                     end
                  end
                  KIND_POP: begin
                     if (empty) begin
                        imm_status = STATUS_EMPTY;
                        new_hint   = 1'b0;
                     end else begin
                        new_t     = tm1;
                        imm_rsp   = 1'b0;
                        ram_re    = 1'b1;
                        ram_raddr = {qi, tm1[AW-1:0]};
                        remain_in = CW'(1);
                        state_in  = BK_DATA;
                     end
                  end
                  KIND_STEAL: begin
                     if (empty) begin
                        imm_status = STATUS_EMPTY;
                     end else begin
                        new_h     = h + IW'(take);
                        imm_rsp   = 1'b0;
                        ram_re    = 1'b1;
                        ram_raddr = {qi, h[AW-1:0]};
                        rd_idx_in = h[AW-1:0] + 1'b1;
                        remain_in = take;
                        state_in  = BK_DATA;
                     end
                  end
                  KIND_CLEAR: begin
                     new_h    = '0;
                     new_t    = '0;
                     new_hint = 1'b0;
                  end
                  default: begin
                  end
               endcase
               new_depth    = DEPTH_W'(new_t - new_h);
               run_depth_in = new_depth;
               run_hint_in  = new_hint;
               rd_q_in      = qi;
               if (imm_rsp) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.out_item   = '0;
                  rsp_data_in.status     = imm_status;
                  rsp_data_in.last       = 1'b1;
                  rsp_data_in.depth_left = new_depth;
                  rsp_data_in.work_hint  = new_hint;
               end
            end
         end
         BK_DATA: begin
            // The memory holds its read word until the output slot frees up.
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_item   = ram_rdata;
               rsp_data_in.status     = STATUS_OK;
               rsp_data_in.last       = (remain_ff == CW'(1));
               rsp_data_in.depth_left = run_depth_ff;
               rsp_data_in.work_hint  = run_hint_ff;
               if (remain_ff == CW'(1)) begin
                  state_in = BK_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  rd_idx_in = rd_idx_ff + 1'b1;
                  remain_in = remain_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            hint_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd_en) begin
            head_ff[qi] <= new_h;
            tail_ff[qi] <= new_t;
            hint_ff[qi] <= new_hint;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      remain_ff    <= remain_in;
      rd_idx_ff    <= rd_idx_in;
      rd_q_ff      <= rd_q_in;
      run_depth_ff <= run_depth_in;
      run_hint_ff  <= run_hint_in;
   end

   wsq_ram #(
      .WIDTH (ITEM_W),
      .DEPTH (RAM_DEPTH)
   ) u_item_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cmd_data.item),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/work_stealing_queue_bank_core.sv
// Path: push, clear and refused or empty commands pass the command queue and the
// result register; pop and steal words also pass the item memory's read register.
// Throughput: one push, clear or refused command per cycle while results are taken;
// a pop or steal stalls later commands while the single read port reads its words.
// Reset is synchronous: all head and tail indices, hints and queued commands clear;
// the steal limit returns to 4; the item memory is not cleared.
module work_stealing_queue_bank_core import wsq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
   parameter int MAX_STEAL   = MAX_STEAL_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0] steal_limit_ff;
   logic               cmd_valid;
   cmd_type            cmd_data;
   logic               cmd_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         steal_limit_ff <= STEAL_LIMIT_RESET;
      end else if (csr_we) begin
         steal_limit_ff <= csr_wdata;
      end
   end

   wsq_front #(
      .NUM_QUEUES (NUM_QUEUES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   wsq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NUM_QUEUES  (NUM_QUEUES),
      .MAX_STEAL   (MAX_STEAL)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .steal_limit (steal_limit_ff),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: hdl/wsq_checker.sv
module wsq_checker import wsq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result word must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   // A refused or empty command ends its run at once and carries no item.
   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.last && rsp_data.out_item == '0)
      else $error("failed command word is not a lone zero word");

   // An empty queue always has head equal to tail.
   a_empty_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.depth_left == '0)
      else $error("empty status with nonzero depth");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

bind work_stealing_queue_bank_core wsq_checker u_wsq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: test/queue_bank_checker.sv
module queue_bank_checker import wsq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata,
   output int                 fail_count,
   output int                 outstanding,
   output int                 words_checked
);

   localparam int QDEPTH = QUEUE_DEPTH_DEF;
   localparam int NQ     = NUM_QUEUES_DEF;
   localparam int MAXS   = MAX_STEAL_DEF;

   logic [DEPTH_W-1:0] head_at [NQ];
   logic [DEPTH_W-1:0] tail_at [NQ];
   logic               hint_at [NQ];
   logic [ITEM_W-1:0]  slot [NQ*QDEPTH];
   logic [LIMIT_W-1:0] limit_now;
   rsp_type            expected_words [$];
   int                 reported;

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      words_checked = 0;
      reported      = 0;
   end

   // Builds one result word from the state of queue q after the command.
   function automatic rsp_type make_word(logic [ITEM_W-1:0] item, status_type st,
                                         logic lst, int q);
      rsp_type w;
      w.out_item   = item;
      w.status     = st;
      w.last       = lst;
      w.depth_left = tail_at[q] - head_at[q];
      w.work_hint  = hint_at[q];
      return w;
   endfunction

   task automatic predict_words(req_type r);
      int q;
      int h;
      int t;
      int lim;
      int take;
      q = int'(r.queue_sel) % NQ;
      h = head_at[q];
      t = tail_at[q];
      case (kind_type'(r.kind))
         KIND_PUSH: begin
            if (t >= QDEPTH) begin
               expected_words.push_back(make_word('0, STATUS_FULL, 1'b1, q));
            end else begin
               slot[q*QDEPTH + t] = r.push_item;
               tail_at[q] = DEPTH_W'(t + 1);
               hint_at[q] = 1'b1;
               expected_words.push_back(make_word('0, STATUS_OK, 1'b1, q));
            end
         end
         KIND_POP: begin
            if (h >= t) begin
               hint_at[q] = 1'b0;
               expected_words.push_back(make_word('0, STATUS_EMPTY, 1'b1, q));
            end else begin
               tail_at[q] = DEPTH_W'(t - 1);
               expected_words.push_back(make_word(slot[q*QDEPTH + t - 1], STATUS_OK,
                                                  1'b1, q));
            end
         end
         KIND_STEAL: begin
            if (h >= t) begin
               expected_words.push_back(make_word('0, STATUS_EMPTY, 1'b1, q));
            end else begin
               lim = limit_now;
               if (lim == 0) lim = 1;
               if (lim > MAXS) lim = MAXS;
               take = (t - h < lim) ? t - h : lim;
               head_at[q] = DEPTH_W'(h + take);
               // Every word of the run reports the depth left after the whole steal.
               for (int i = 0; i < take; i++) begin
                  expected_words.push_back(make_word(slot[q*QDEPTH + h + i], STATUS_OK,
                                                     i == take - 1, q));
               end
            end
         end
         default: begin
            head_at[q] = '0;
            tail_at[q] = '0;
            hint_at[q] = 1'b0;
            expected_words.push_back(make_word('0, STATUS_OK, 1'b1, q));
         end
      endcase
      outstanding = expected_words.size();
   endtask

   task automatic check_word(rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         fail_count++;
         if (reported < 10) begin
            reported++;
            $display("unexpected result word: item %h status %0d last %0d depth %0d hint %0d",
                     got.out_item, got.status, got.last, got.depth_left, got.work_hint);
         end
         return;
      end
      want = expected_words.pop_front();
      outstanding = expected_words.size();
      words_checked++;
      if (got.out_item !== want.out_item || got.status !== want.status ||
          got.last !== want.last || got.depth_left !== want.depth_left ||
          got.work_hint !== want.work_hint) begin
         fail_count++;
         if (reported < 10) begin
            reported++;
            $display("mismatch on word %0d: expected item %h status %0d last %0d depth %0d hint %0d",
                     words_checked, want.out_item, want.status, want.last,
                     want.depth_left, want.work_hint);
            $display("                     actual   item %h status %0d last %0d depth %0d hint %0d",
                     got.out_item, got.status, got.last, got.depth_left, got.work_hint);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            head_at[i] = '0;
            tail_at[i] = '0;
            hint_at[i] = 1'b0;
         end
         limit_now = STEAL_LIMIT_RESET;
         expected_words.delete();
         outstanding = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_word(rsp_data);
         if (req_valid && req_ready) predict_words(req_data);
         if (csr_we) limit_now = csr_wdata;
      end
   end

endmodule

FILE: test/tb_work_stealing_queue_bank_core.sv
module tb_work_stealing_queue_bank_core;
   import wsq_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_we;
   logic [LIMIT_W-1:0] csr_wdata;

   int fail_count;
   int outstanding;
   int words_checked;
   int cycles = 0;
   int kind_seen [4];
   int limit_writes;
   int hot [4];
   bit calm;
   bit rsp_calm;

   work_stealing_queue_bank_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   queue_bank_checker bank_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [ITEM_W-1:0] rand_item();
      return {$urandom, $urandom};
   endfunction

   // Result side: a fresh stall is drawn for every word; now and then it runs with no stalls.
   initial begin : result_sink
      int gap;
      rsp_ready = 1'b0;
      rsp_calm  = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
         gap = rsp_calm ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Called and returning at a falling edge.
   task automatic send_cmd(kind_type k, int q, logic [ITEM_W-1:0] item);
      req_type word;
      int gap;
      word.kind      = k;
      word.queue_sel = SEL_W'(q);
      word.push_item = item;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!(req_valid && req_ready));
      kind_seen[k]++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_limit(logic [LIMIT_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      limit_writes++;
   endtask

   function automatic kind_type pick_kind();
      int w;
      w = $urandom_range(0, 99);
      if (w < 45) return KIND_PUSH;
      if (w < 65) return KIND_POP;
      if (w < 93) return KIND_STEAL;
      return KIND_CLEAR;
   endfunction

   // Fills one queue to capacity, then shows that steals do not make room for a push.
   task automatic fill_to_full(int q);
      calm = 1'b1;
      send_cmd(KIND_CLEAR, q, rand_item());
      repeat (QUEUE_DEPTH_DEF) send_cmd(KIND_PUSH, q, rand_item());
      repeat (3) send_cmd(KIND_PUSH, q, rand_item());
      send_cmd(KIND_STEAL, q, rand_item());
      send_cmd(KIND_PUSH, q, rand_item());
      send_cmd(KIND_POP, q, rand_item());
      send_cmd(KIND_PUSH, q, rand_item());
      send_cmd(KIND_PUSH, q, rand_item());
      send_cmd(KIND_CLEAR, q, rand_item());
      calm = 1'b0;
   endtask

   task automatic run_random(int count);
      int done;
      int r;
      int q;
      int len;
      int steals;
      done = 0;
      for (int i = 0; i < 4; i++) hot[i] = $urandom_range(0, 15);
      calm = ($urandom_range(0, 3) == 0);
      while (done < count) begin
         r = $urandom_range(0, 9);
         q = hot[$urandom_range(0, 3)];
         if (r <= 5) begin
            send_cmd(pick_kind(), q, rand_item());
            done++;
         end else if (r <= 8) begin
            // A burst of pushes drained by a few steals and maybe a pop.
            len    = $urandom_range(1, 20);
            steals = $urandom_range(1, 4);
            repeat (len) send_cmd(KIND_PUSH, q, rand_item());
            repeat (steals) send_cmd(KIND_STEAL, q, rand_item());
            if ($urandom_range(0, 1) == 1) send_cmd(KIND_POP, q, rand_item());
            done += len + steals;
         end else begin
            send_cmd(kind_type'($urandom_range(0, 3)), $urandom_range(0, 15), rand_item());
            done++;
         end
      end
      calm = 1'b0;
   endtask

   initial begin : stimulus
      logic [LIMIT_W-1:0] limits [7];
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      calm      = 1'b0;
      limit_writes = 0;
      for (int i = 0; i < 4; i++) kind_seen[i] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset steal limit.
      send_cmd(KIND_POP, 0, '1);
      send_cmd(KIND_STEAL, 0, '1);
      send_cmd(KIND_PUSH, 0, '0);
      send_cmd(KIND_PUSH, 0, '1);
      send_cmd(KIND_PUSH, 0, 64'hA5A5_A5A5_A5A5_A5A5);
      send_cmd(KIND_PUSH, 0, 64'h5A5A_5A5A_5A5A_5A5A);
      send_cmd(KIND_POP, 0, '0);
      send_cmd(KIND_STEAL, 0, 64'h1234_5678_9ABC_DEF0);
      send_cmd(KIND_STEAL, 0, '0);
      send_cmd(KIND_POP, 0, '0);
      for (int i = 0; i < 5; i++) send_cmd(KIND_PUSH, 15, rand_item());
      send_cmd(KIND_STEAL, 15, '0);
      send_cmd(KIND_POP, 15, '0);
      send_cmd(KIND_CLEAR, 15, '1);
      send_cmd(KIND_POP, 15, '0);
      send_cmd(KIND_STEAL, 15, '0);
      send_cmd(KIND_PUSH, 7, '1);
      send_cmd(KIND_CLEAR, 7, '1);
      send_cmd(KIND_CLEAR, 3, '0);

      limits = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, STEAL_LIMIT_RESET,
                 LIMIT_W'($urandom_range(2, 15))};
      foreach (limits[i]) begin
         set_limit(limits[i]);
         if (limits[i] == 5'd16) fill_to_full(9);
         run_random(3);
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      $display("tb: %0d commands (push %0d, pop %0d, steal %0d, clear %0d), %0d words checked",
               kind_seen[0] + kind_seen[1] + kind_seen[2] + kind_seen[3], kind_seen[0],
               kind_seen[1], kind_seen[2], kind_seen[3], words_checked);
      $display("tb: %0d steal limit settings including 0, 1, 16 and above, one queue run to capacity",
               limit_writes);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
